/* sv/soa_pkg.sv */
package soa_pkg;
  localparam int unsigned Frames  = 16;
  localparam int unsigned Objects = 128;
  localparam int unsigned FrameW  = 4;
  localparam int unsigned ObjW    = 7;
  localparam int unsigned CellW   = FrameW + ObjW;
  localparam logic [7:0] ChainEnd = 8'hFF;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoFrame = 2'd1;
  localparam logic [1:0] StBadFree = 2'd2;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  typedef struct packed {
    logic             we;
    logic [CellW-1:0] waddr;
    logic [7:0]       wdata;
    logic [CellW-1:0] raddr;
  } chain_req_t;
endpackage

/* sv/soa_chain_ram.sv */
module soa_chain_ram (
  input  logic                    clk_i,
  input  soa_pkg::chain_req_t     req_i,
  output logic [7:0]              rdata_o
);
  logic [7:0] mem_q [soa_pkg::Frames*soa_pkg::Objects];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end
endmodule

/* sv/slab_object_allocator_unit.sv */
// channel | dir | signals
// cfg     | in  | cfg_valid_i, cfg_ready_o, cfg_data_i[7:0]
// req     | in  | req_valid_i, req_ready_o, func_i, slab_index_i, object_index_i
// rsp     | out | rsp_valid_o, rsp_ready_i, status_o, alloc_slab_o, alloc_object_o,
//         |     | slab_became_full_o, slab_released_o
// From accept to result: a rejected free or an allocate with no free frame goes from decode
// to the response; a free passes the free state; an allocate passes read, then pop unless its head is bad.
// Activating a frame first writes one chain word a cycle, one word per slot (the slot
// count clamped to 1..128). Reset takes effect at once, no clearing pass.
// Request and config are ready only in idle, entered in the cycle after the result word is taken.
module slab_object_allocator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  logic       func_i,
  input  logic [3:0] slab_index_i,
  input  logic [6:0] object_index_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output logic [1:0] status_o,
  output logic [3:0] alloc_slab_o,
  output logic [6:0] alloc_object_o,
  output logic       slab_became_full_o,
  output logic       slab_released_o
);
  localparam int unsigned FW = soa_pkg::FrameW;
  localparam int unsigned OW = soa_pkg::ObjW;
  localparam int unsigned N  = soa_pkg::Frames;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_INIT  = 7'b0000100,
    S_RD    = 7'b0001000,
    S_POP   = 7'b0010000,
    S_FREE  = 7'b0100000,
    S_RSP   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [7:0] cfg_q;
  logic [7:0] head_q [N];
  logic [7:0] cnt_q [N];
  logic [N-1:0] act_q, onl_q;
  logic [FW:0] fwd_q [N];
  logic [FW:0] bwd_q [N];
  logic [FW:0] nfh_q;
  logic func_q;
  logic [FW-1:0] s_q;
  logic [OW-1:0] o_q;
  logic [7:0] i_q;
  logic [1:0] st_q;
  logic [FW-1:0] as_q;
  logic [OW-1:0] ao_q;
  logic full_q, rel_q;
  soa_pkg::chain_req_t creq;
  logic [7:0] rdata;
  logic [7:0] nslots;
  logic [FW-1:0] first_free;
  logic found;

  soa_chain_ram u_ram (.clk_i(clk_i), .req_i(creq), .rdata_o(rdata));

  always_comb begin
    nslots = cfg_q;
    if (nslots == 8'd0) nslots = 8'd1;
    if (nslots > 8'(soa_pkg::Objects)) nslots = 8'(soa_pkg::Objects);
    found = 1'b0;
    first_free = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (!act_q[k]) begin
        found = 1'b1;
        first_free = FW'(k);
      end
    end
  end

  assign cfg_ready_o = (state_q == S_IDLE);
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RSP);
  assign status_o = st_q;
  assign alloc_slab_o = as_q;
  assign alloc_object_o = ao_q;
  assign slab_became_full_o = full_q;
  assign slab_released_o = rel_q;

  always_comb begin
    creq.we = 1'b0;
    creq.waddr = {s_q, o_q};
    creq.wdata = head_q[s_q];
    creq.raddr = {nfh_q[FW-1:0], head_q[nfh_q[FW-1:0]][OW-1:0]};
    if (state_q == S_INIT) begin
      creq.we = 1'b1;
      creq.waddr = {s_q, i_q[OW-1:0]};
      creq.wdata = (i_q + 8'd1 == nslots) ? soa_pkg::ChainEnd : i_q + 8'd1;
    end else if (state_q == S_FREE) begin
      creq.we = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_valid_i) state_d = S_DEC;
      S_DEC: begin
        if (func_q == soa_pkg::FuncFree) begin
          state_d = (!act_q[s_q] || 8'(o_q) >= nslots) ? S_RSP : S_FREE;
        end else if (nfh_q[FW]) begin
          state_d = found ? S_INIT : S_RSP;
        end else begin
          state_d = S_RD;
        end
      end
      S_INIT: if (i_q + 8'd1 == nslots) state_d = S_RD;
      S_RD: state_d = head_q[nfh_q[FW-1:0]][7] ? S_RSP : S_POP;
      S_POP: state_d = S_RSP;
      S_FREE: state_d = S_RSP;
      S_RSP: if (rsp_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state and register updates with list unlink and push of frames; hs and c are blocking copies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [FW-1:0] hs;
    logic [7:0] c;
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cfg_q <= 8'd128;
      act_q <= '0;
      onl_q <= '0;
      nfh_q <= {1'b1, {FW{1'b0}}};
      for (int k = 0; k < N; k++) cnt_q[k] <= 8'd0;
    end else begin
      state_q <= state_d;
      hs = nfh_q[FW-1:0];
      c = cnt_q[s_q];
      if (cfg_valid_i && cfg_ready_o) cfg_q <= cfg_data_i;
      unique case (state_q)
        S_IDLE: begin
          func_q <= func_i;
          s_q <= slab_index_i;
          o_q <= object_index_i;
          st_q <= soa_pkg::StOk;
          as_q <= '0;
          ao_q <= '0;
          full_q <= 1'b0;
          rel_q <= 1'b0;
          i_q <= 8'd0;
        end
        S_DEC: begin
          if (func_q == soa_pkg::FuncFree) begin
            if (!act_q[s_q]) st_q <= soa_pkg::StBadFree;
          end else if (nfh_q[FW]) begin
            if (!found) st_q <= soa_pkg::StNoFrame;
            else s_q <= first_free;
          end
        end
        S_INIT: begin
          i_q <= i_q + 8'd1;
          if (i_q + 8'd1 == nslots) begin
            head_q[s_q] <= 8'd0;
            cnt_q[s_q] <= 8'd0;
            act_q[s_q] <= 1'b1;
            onl_q[s_q] <= 1'b1;
            fwd_q[s_q] <= nfh_q;
            bwd_q[s_q] <= {1'b1, {FW{1'b0}}};
            nfh_q <= {1'b0, s_q};
          end
        end
        S_RD: begin
          if (head_q[hs][7]) begin
            st_q <= soa_pkg::StNoFrame;
            onl_q[hs] <= 1'b0;
            nfh_q <= fwd_q[hs];
            if (!fwd_q[hs][FW]) bwd_q[fwd_q[hs][FW-1:0]] <= {1'b1, {FW{1'b0}}};
          end else begin
            if (cnt_q[hs] != 8'hFF) cnt_q[hs] <= cnt_q[hs] + 8'd1;
            as_q <= hs;
            ao_q <= head_q[hs][OW-1:0];
          end
        end
        S_POP: begin
          head_q[hs] <= rdata;
          if (rdata[7]) begin
            full_q <= 1'b1;
            onl_q[hs] <= 1'b0;
            nfh_q <= fwd_q[hs];
            if (!fwd_q[hs][FW]) bwd_q[fwd_q[hs][FW-1:0]] <= {1'b1, {FW{1'b0}}};
          end
        end
        S_FREE: begin
          head_q[s_q] <= {1'b0, o_q};
          c = (c != 8'd0) ? c - 8'd1 : 8'd0;
          cnt_q[s_q] <= c;
          if (c == 8'd0 || c == nslots - 8'd1) begin
            // empty: deactivate and unlink (if on list); else push to head or move to head
            if (c == 8'd0) begin
              act_q[s_q] <= 1'b0;
              rel_q <= 1'b1;
              onl_q[s_q] <= 1'b0;
              if (onl_q[s_q]) begin
                if (bwd_q[s_q][FW]) nfh_q <= fwd_q[s_q];
                else fwd_q[bwd_q[s_q][FW-1:0]] <= fwd_q[s_q];
                if (!fwd_q[s_q][FW]) bwd_q[fwd_q[s_q][FW-1:0]] <= bwd_q[s_q];
              end
            end else if (!onl_q[s_q]) begin
              onl_q[s_q] <= 1'b1;
              fwd_q[s_q] <= nfh_q;
              bwd_q[s_q] <= {1'b1, {FW{1'b0}}};
              if (!nfh_q[FW]) bwd_q[hs] <= {1'b0, s_q};
              nfh_q <= {1'b0, s_q};
            end else if (!(bwd_q[s_q][FW])) begin
              // on list, not at head: move to head
              fwd_q[bwd_q[s_q][FW-1:0]] <= fwd_q[s_q];
              if (!fwd_q[s_q][FW]) bwd_q[fwd_q[s_q][FW-1:0]] <= bwd_q[s_q];
              fwd_q[s_q] <= nfh_q;
              bwd_q[s_q] <= {1'b1, {FW{1'b0}}};
              bwd_q[hs] <= {1'b0, s_q};
              nfh_q <= {1'b0, s_q};
            end
          end
        end
        S_RSP: ;
        default: ;
      endcase
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(status_o))
    else $error("response dropped");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_o && rsp_valid_o)) else $error("ready during response");
  a_full_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (slab_became_full_o || slab_released_o) |-> status_o == soa_pkg::StOk)
    else $error("flag with error status");
  a_head_listed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && !nfh_q[FW] |-> onl_q[nfh_q[FW-1:0]])
    else $error("list head not listed");
endmodule
